// ===== rtl/iwsd_pkg.sv =====
// ============================================================================
// iwsd_pkg: shared types and constants for the IMU window static detector
// Window geometry, derived datapath widths, stage payload structs and the
// codes used on the command and configuration ports.
// ============================================================================
`default_nettype none

package iwsd_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Window and detector geometry
    localparam int WINDOW_LEN   = 200;
    localparam int STATIC_LIMIT = 50;
    localparam int SAMPLE_BITS  = 16;

    // Fixed field widths on the ports
    localparam int FIELD_W    = 16;
    localparam int TIME_W     = 32;
    localparam int ACC_THR_W  = 32;
    localparam int GYRO_THR_W = 16;
    localparam int LEVEL_W    = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam int S_TDATA_W = 8 * ((TIME_W + 6 * FIELD_W + 7) / 8);
    localparam int M_TDATA_W = 8 * ((2 + LEVEL_W + TIME_W + 7) / 8);

    // Derived widths
    localparam int SLOT_W   = $clog2(WINDOW_LEN);
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int N_W      = FILL_W;
    localparam int NN_W     = $clog2(WINDOW_LEN * WINDOW_LEN + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int SQSUM_W  = 2 * SAMPLE_BITS + $clog2(3 * WINDOW_LEN);
    localparam int SSQ_W    = 2 * SUM_W;
    localparam int GN_W     = GYRO_THR_W + N_W;
    localparam int CMP_W    = imax(imax(SQSUM_W + N_W, SSQ_W + 2),
                                   imax(ACC_THR_W + NN_W, 2 * GN_W)) + 1;
    localparam int CNT_W    = $clog2(STATIC_LIMIT + 1);

    // Result queue: a power of two so the pointers wrap on their own
    localparam int OUT_PTR_W = 3;
    localparam int OUT_DEPTH = 1 << OUT_PTR_W;
    localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        CMD_FEED  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACC_VAR_THR   = 1'b0,
        REG_GYRO_MEAN_THR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] gz;
        logic [SAMPLE_BITS-1:0] gy;
        logic [SAMPLE_BITS-1:0] gx;
        logic [SAMPLE_BITS-1:0] az;
        logic [SAMPLE_BITS-1:0] ay;
        logic [SAMPLE_BITS-1:0] ax;
    } sample_t;

    // Per-item bookkeeping that rides along the whole pipeline
    typedef struct packed {
        cmd_t              cmd;
        logic              accepted;
        logic              full;
        logic [TIME_W-1:0] newest_time;
    } item_tag_t;

    typedef struct packed {
        item_tag_t tag;
        sample_t   smp;
    } stage1_t;

    typedef struct packed {
        item_tag_t                   tag;
        logic [2:0][SAMPLE_BITS:0]   dsum_a;
        logic [2:0][SAMPLE_BITS:0]   dsum_g;
        logic [2:0][SQ_W-1:0]        sq_new;
        logic [2:0][SQ_W-1:0]        sq_old;
    } stage2_t;

    typedef struct packed {
        item_tag_t             tag;
        logic [2:0][SSQ_W-1:0] ssq_a;
        logic [2:0][SSQ_W-1:0] ssq_g;
        logic [CMP_W-1:0]      nsq;
        logic [CMP_W-1:0]      var_rhs;
        logic [GN_W-1:0]       gn;
    } stage3_t;

    typedef struct packed {
        item_tag_t        tag;
        logic [CMP_W-1:0] nsq;
        logic [CMP_W-1:0] asq_tot;
        logic [CMP_W-1:0] var_rhs;
        logic [CMP_W-1:0] gsq_tot;
        logic [CMP_W-1:0] gyro_rhs;
    } stage4_t;

    // Result word, accepted in the lowest bit
    typedef struct packed {
        logic [TIME_W-1:0]  newest_time;
        logic [LEVEL_W-1:0] static_level;
        logic               is_static;
        logic               accepted;
    } result_t;

    // Take the low SAMPLE_BITS of a raw count as two's complement
    function automatic logic [SAMPLE_BITS-1:0] take_sample(input logic [FIELD_W-1:0] v);
        logic [SAMPLE_BITS+FIELD_W-1:0] wide;
        wide = {{SAMPLE_BITS{1'b0}}, v};
        return wide[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/imu_window_static_detector.sv =====
// ============================================================================
// imu_window_static_detector: sliding-window IMU stationarity detector
// Stores time-ordered IMU samples in a ring of the newest WINDOW_LEN
// entries with running sums, and on query tests accelerometer variance and
// mean gyro norm against programmable limits, stepping a saturating counter.
// ============================================================================
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ---------------------------------
//  s_*       in         s_tvalid/s_tready  tdata: sample time, accel, gyro
//                                          tuser: command (feed or query)
//  m_*       out        m_tvalid/m_tready  tdata: accepted, is_static,
//                                          static level, newest time
//  cfg_*     in         cfg_wr_en          index 0 accel limit, 1 gyro limit
//
//  One item per clock sustained while the sink keeps up. An item passes four
//  register stages and is written into an eight-entry result queue, from
//  which its result is offered on m_*. The window memory is read and
//  written once per stored sample on the same address.
//  Reset clears the sums, counters and timestamp; the window memory is not
//  cleared, since data read from an entry not yet written is discarded.
//  Input ready depends only on the count of items in flight plus queued
//  results, so a stalled sink blocks intake only once the queue is spoken for;
//  with the sink always ready at most five items are outstanding.
//
`default_nettype none

module imu_window_static_detector
    import iwsd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] sample_time, [47:32] accel_x, [63:48] accel_y, [79:64] accel_z,
    // [95:80] gyro_x, [111:96] gyro_y, [127:112] gyro_z
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] cmd
    input  wire logic                  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] accepted, [1] is_static, [7:2] static_level, [39:8] newest_time
    output logic [M_TDATA_W-1:0]       m_tdata,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [ACC_THR_W-1:0]  acc_thr_reg, acc_thr_next;
    logic [GYRO_THR_W-1:0] gyro_thr_reg, gyro_thr_next;

    // Window control state
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              have_sample_reg, have_sample_next;

    // Credit count: items in flight plus queued results
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic              p1_valid_reg, p1_valid_next;
    stage1_t           p1_reg, p1_next;

    logic              in_xfer;
    logic              out_xfer;
    cmd_t              in_cmd;
    logic [TIME_W-1:0] in_time;
    sample_t           in_smp;
    logic              feed_ok;
    logic              store;
    logic              win_full;

    sample_t           old_smp;
    logic              p3_valid;
    stage3_t           p3;
    logic              res_valid;
    result_t           res;
    logic              fifo_valid;
    result_t           fifo_data;

    // Unpack the incoming transfer
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_time   = s_tdata[TIME_W-1:0];
    assign in_smp.ax = take_sample(s_tdata[TIME_W +     FIELD_W-1 -: FIELD_W]);
    assign in_smp.ay = take_sample(s_tdata[TIME_W + 2 * FIELD_W-1 -: FIELD_W]);
    assign in_smp.az = take_sample(s_tdata[TIME_W + 3 * FIELD_W-1 -: FIELD_W]);
    assign in_smp.gx = take_sample(s_tdata[TIME_W + 4 * FIELD_W-1 -: FIELD_W]);
    assign in_smp.gy = take_sample(s_tdata[TIME_W + 5 * FIELD_W-1 -: FIELD_W]);
    assign in_smp.gz = take_sample(s_tdata[TIME_W + 6 * FIELD_W-1 -: FIELD_W]);

    assign s_tready = (occ_reg < OCC_W'(OUT_DEPTH));
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = fifo_valid && m_tready;

    // Store a feed only if its timestamp moves forward (first one always)
    assign feed_ok  = (in_cmd == CMD_FEED) && (!have_sample_reg || (in_time > last_time_reg));
    assign store    = in_xfer && feed_ok;
    assign win_full = (fill_count_reg == FILL_W'(WINDOW_LEN));

    // Configuration writes
    always_comb begin
        acc_thr_next  = acc_thr_reg;
        gyro_thr_next = gyro_thr_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ACC_VAR_THR:   acc_thr_next  = cfg_wdata[ACC_THR_W-1:0];
                REG_GYRO_MEAN_THR: gyro_thr_next = cfg_wdata[GYRO_THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the ring pointer, fill level and timestamp on each stored sample
    always_comb begin
        write_slot_next  = write_slot_reg;
        fill_count_next  = fill_count_reg;
        last_time_next   = last_time_reg;
        have_sample_next = have_sample_reg;
        if (store) begin
            if (write_slot_reg == SLOT_W'(WINDOW_LEN - 1)) begin
                write_slot_next = '0;
            end else begin
                write_slot_next = write_slot_reg + 1'b1;
            end
            if (!win_full) begin
                fill_count_next = fill_count_reg + 1'b1;
            end
            last_time_next   = in_time;
            have_sample_next = 1'b1;
        end
    end

    always_comb begin
        occ_next = occ_reg + OCC_W'(in_xfer) - OCC_W'(out_xfer);
    end

    // Stage 1 register: memory read data lines up with this stage
    always_comb begin
        p1_valid_next            = in_xfer;
        p1_next.tag.cmd          = in_cmd;
        p1_next.tag.accepted     = feed_ok;
        p1_next.tag.full         = win_full;
        p1_next.tag.newest_time  = feed_ok ? in_time : last_time_reg;
        p1_next.smp              = in_smp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_thr_reg     <= ACC_THR_W'(400);
            gyro_thr_reg    <= GYRO_THR_W'(10);
            write_slot_reg  <= '0;
            fill_count_reg  <= '0;
            last_time_reg   <= '0;
            have_sample_reg <= 1'b0;
            occ_reg         <= '0;
            p1_valid_reg    <= 1'b0;
        end else begin
            acc_thr_reg     <= acc_thr_next;
            gyro_thr_reg    <= gyro_thr_next;
            write_slot_reg  <= write_slot_next;
            fill_count_reg  <= fill_count_next;
            last_time_reg   <= last_time_next;
            have_sample_reg <= have_sample_next;
            occ_reg         <= occ_next;
            p1_valid_reg    <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg <= p1_next;
    end

    // Read the evicted sample and write the new one in the same cycle
    iwsd_window_mem u_window_mem (
        .aclk    (aclk),
        .wr_en   (store),
        .slot    (write_slot_reg),
        .wr_data (in_smp),
        .rd_data (old_smp)
    );

    iwsd_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .p1_valid (p1_valid_reg),
        .p1       (p1_reg),
        .old_smp  (old_smp),
        .acc_thr  (acc_thr_reg),
        .gyro_thr (gyro_thr_reg),
        .p3_valid (p3_valid),
        .p3       (p3)
    );

    iwsd_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .p3_valid  (p3_valid),
        .p3        (p3),
        .res_valid (res_valid),
        .res       (res)
    );

    iwsd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tready),
        .out_valid (fifo_valid),
        .out_data  (fifo_data)
    );

    assign m_tvalid = fifo_valid;
    assign m_tdata  = M_TDATA_W'(fifo_data);

    // Credits never exceed the queue depth, so the queue cannot overflow
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(OUT_DEPTH))
        else $error("credit count above result queue depth");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(WINDOW_LEN))
        else $error("fill count above window length");

    // Until the ring first wraps, the write slot tracks the fill level
    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_count_reg != FILL_W'(WINDOW_LEN)) |->
            (FILL_W'(write_slot_reg) == fill_count_reg))
        else $error("write slot out of step with fill count");

    a_time_update: assert property (@(posedge aclk) disable iff (!aresetn)
        store |=> (last_time_reg == $past(in_time)))
        else $error("stored sample did not update newest timestamp");

endmodule

`default_nettype wire

// ===== rtl/iwsd_window_mem.sv =====
// ============================================================================
// iwsd_window_mem: sample ring storage
// One synchronous memory of WINDOW_LEN samples. Read-first on a shared
// address: the read returns the oldest sample while the new one replaces it.
// ============================================================================
`default_nettype none

module iwsd_window_mem
    import iwsd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire sample_t           wr_data,
    output sample_t                rd_data
);

    sample_t mem [WINDOW_LEN];
    sample_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rd_data_reg <= mem[slot];
            mem[slot]   <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/iwsd_accum.sv =====
// ============================================================================
// iwsd_accum: running sums and query snapshot
// Square the new and evicted samples, fold them into the running sums, and
// for each item take the products that the stationarity test needs.
// ============================================================================
`default_nettype none

module iwsd_accum
    import iwsd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  p1_valid,
    input  wire stage1_t               p1,
    input  wire sample_t               old_smp,
    input  wire logic [ACC_THR_W-1:0]  acc_thr,
    input  wire logic [GYRO_THR_W-1:0] gyro_thr,
    output logic                       p3_valid,
    output stage3_t                    p3
);

    localparam logic [N_W-1:0]  N_VAL  = N_W'(WINDOW_LEN);
    localparam logic [NN_W-1:0] NN_VAL = NN_W'(WINDOW_LEN * WINDOW_LEN);

    logic    p2_valid_reg, p2_valid_next;
    stage2_t p2_reg, p2_next;
    logic    p3_valid_reg, p3_valid_next;
    stage3_t p3_reg, p3_next;

    logic signed [SUM_W-1:0] acc_sum_reg  [3];
    logic signed [SUM_W-1:0] acc_sum_next [3];
    logic signed [SUM_W-1:0] gyr_sum_reg  [3];
    logic signed [SUM_W-1:0] gyr_sum_next [3];
    logic [SQSUM_W-1:0]      sqsum_reg, sqsum_next;

    logic [SQSUM_W+N_W-1:0]    nsq_full;
    logic [ACC_THR_W+NN_W-1:0] rhs_full;

    // S1: squares and signed deltas of the new and evicted samples
    always_comb begin
        logic signed [SAMPLE_BITS-1:0] n_a [3];
        logic signed [SAMPLE_BITS-1:0] n_g [3];
        logic signed [SAMPLE_BITS-1:0] o_a [3];
        logic signed [SAMPLE_BITS-1:0] o_g [3];
        logic signed [SQ_W-1:0]        sq_n;
        logic signed [SQ_W-1:0]        sq_o;
        logic signed [SAMPLE_BITS:0]   ev_a;
        logic signed [SAMPLE_BITS:0]   ev_g;
        n_a[0] = p1.smp.ax; n_a[1] = p1.smp.ay; n_a[2] = p1.smp.az;
        n_g[0] = p1.smp.gx; n_g[1] = p1.smp.gy; n_g[2] = p1.smp.gz;
        o_a[0] = old_smp.ax; o_a[1] = old_smp.ay; o_a[2] = old_smp.az;
        o_g[0] = old_smp.gx; o_g[1] = old_smp.gy; o_g[2] = old_smp.gz;
        p2_valid_next = p1_valid;
        p2_next.tag   = p1.tag;
        for (int i = 0; i < 3; i++) begin
            sq_n = n_a[i] * n_a[i];
            sq_o = o_a[i] * o_a[i];
            ev_a = p1.tag.full ? (SAMPLE_BITS+1)'(o_a[i]) : '0;
            ev_g = p1.tag.full ? (SAMPLE_BITS+1)'(o_g[i]) : '0;
            p2_next.sq_new[i] = sq_n;
            p2_next.sq_old[i] = p1.tag.full ? sq_o : '0;
            p2_next.dsum_a[i] = (SAMPLE_BITS+1)'(n_a[i]) - ev_a;
            p2_next.dsum_g[i] = (SAMPLE_BITS+1)'(n_g[i]) - ev_g;
        end
    end

    // S2: fold stored feeds into the sums
    always_comb begin
        logic apply;
        apply = p2_valid_reg && (p2_reg.tag.cmd == CMD_FEED) && p2_reg.tag.accepted;
        for (int i = 0; i < 3; i++) begin
            acc_sum_next[i] = acc_sum_reg[i];
            gyr_sum_next[i] = gyr_sum_reg[i];
            if (apply) begin
                acc_sum_next[i] = acc_sum_reg[i] + SUM_W'($signed(p2_reg.dsum_a[i]));
                gyr_sum_next[i] = gyr_sum_reg[i] + SUM_W'($signed(p2_reg.dsum_g[i]));
            end
        end
        sqsum_next = sqsum_reg;
        if (apply) begin
            sqsum_next = sqsum_reg
                       + SQSUM_W'(p2_reg.sq_new[0]) + SQSUM_W'(p2_reg.sq_new[1])
                       + SQSUM_W'(p2_reg.sq_new[2]) - SQSUM_W'(p2_reg.sq_old[0])
                       - SQSUM_W'(p2_reg.sq_old[1]) - SQSUM_W'(p2_reg.sq_old[2]);
        end
    end

    // S2: snapshot products from the sums as they stand before this item
    assign nsq_full = sqsum_reg * N_VAL;
    assign rhs_full = acc_thr * NN_VAL;

    always_comb begin
        logic signed [SSQ_W-1:0] pa;
        logic signed [SSQ_W-1:0] pg;
        p3_valid_next = p2_valid_reg;
        p3_next.tag   = p2_reg.tag;
        for (int i = 0; i < 3; i++) begin
            pa = acc_sum_reg[i] * acc_sum_reg[i];
            pg = gyr_sum_reg[i] * gyr_sum_reg[i];
            p3_next.ssq_a[i] = pa;
            p3_next.ssq_g[i] = pg;
        end
        p3_next.nsq     = CMP_W'(nsq_full);
        p3_next.var_rhs = CMP_W'(rhs_full);
        p3_next.gn      = gyro_thr * N_VAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            sqsum_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                acc_sum_reg[i] <= '0;
                gyr_sum_reg[i] <= '0;
            end
        end else begin
            p2_valid_reg <= p2_valid_next;
            p3_valid_reg <= p3_valid_next;
            sqsum_reg    <= sqsum_next;
            for (int i = 0; i < 3; i++) begin
                acc_sum_reg[i] <= acc_sum_next[i];
                gyr_sum_reg[i] <= gyr_sum_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        p2_reg <= p2_next;
        p3_reg <= p3_next;
    end

    assign p3_valid = p3_valid_reg;
    assign p3       = p3_reg;

endmodule

`default_nettype wire

// ===== rtl/iwsd_decide.sv =====
// ============================================================================
// iwsd_decide: stationarity test and static counter
// Reduce the snapshot products, compare against the limits, step the
// saturating counter and form the result word.
// ============================================================================
`default_nettype none

module iwsd_decide
    import iwsd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    p3_valid,
    input  wire stage3_t p3,
    output logic         res_valid,
    output result_t      res
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(STATIC_LIMIT);

    logic    p4_valid_reg, p4_valid_next;
    stage4_t p4_reg, p4_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2*GN_W-1:0] gyro_rhs_full;
    logic [CMP_W-1:0]  var_lhs;
    logic              pass;
    logic              run_test;

    // S3: sums of squares and the gyro limit squared
    assign gyro_rhs_full = p3.gn * p3.gn;

    always_comb begin
        p4_valid_next    = p3_valid;
        p4_next.tag      = p3.tag;
        p4_next.nsq      = p3.nsq;
        p4_next.var_rhs  = p3.var_rhs;
        p4_next.asq_tot  = CMP_W'(p3.ssq_a[0]) + CMP_W'(p3.ssq_a[1]) + CMP_W'(p3.ssq_a[2]);
        p4_next.gsq_tot  = CMP_W'(p3.ssq_g[0]) + CMP_W'(p3.ssq_g[1]) + CMP_W'(p3.ssq_g[2]);
        p4_next.gyro_rhs = CMP_W'(gyro_rhs_full);
    end

    // S4: compare and step the counter
    assign var_lhs  = p4_reg.nsq - p4_reg.asq_tot;
    assign pass     = (var_lhs < p4_reg.var_rhs) && (p4_reg.gsq_tot < p4_reg.gyro_rhs);
    assign run_test = p4_valid_reg && (p4_reg.tag.cmd == CMD_QUERY) && p4_reg.tag.full;

    always_comb begin
        cnt_next = cnt_reg;
        if (run_test) begin
            if (pass) begin
                if (cnt_reg < LIMIT) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end else if (cnt_reg != '0) begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_comb begin
        res_valid          = p4_valid_reg;
        res.accepted       = p4_reg.tag.accepted;
        res.static_level   = LEVEL_W'(cnt_next);
        res.newest_time    = p4_reg.tag.newest_time;
        if (p4_reg.tag.cmd == CMD_QUERY) begin
            res.is_static = p4_reg.tag.full && (cnt_next == LIMIT);
        end else begin
            res.is_static = (cnt_next == LIMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            p4_valid_reg <= p4_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        p4_reg <= p4_next;
    end

endmodule

`default_nettype wire

// ===== rtl/iwsd_out_fifo.sv =====
// ============================================================================
// iwsd_out_fifo: result queue
// Small register queue that holds finished results until the sink takes
// them, so the pipeline never stalls.
// ============================================================================
`default_nettype none

module iwsd_out_fifo
    import iwsd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output logic         out_valid,
    output result_t      out_data
);

    result_t               mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]      count_reg, count_next;
    logic                  do_pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OCC_W'(push) - OCC_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== test/imu_window_static_detector_tb.sv =====
// ============================================================================
// imu_window_static_detector_tb: self-checking bench for the window detector
// Streams feed and query transfers with random gaps on both channels,
// predicts every result with a cycle-free model of the sliding window and
// the static counter, and compares each result field by field in order.
// ============================================================================
module imu_window_static_detector_tb;
    import iwsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;      // result latency plus margin
    localparam int WATCHDOG_LIMIT = 5000;   // cycles without any transfer

    // Shape of the motion that a fed sample imitates
    typedef enum int {
        MOTION_QUIET,   // small noise around a fixed attitude
        MOTION_SHAKE,   // large accelerometer swing
        MOTION_SPIN,    // steady rotation on the gyro axes
        MOTION_WILD     // every bit random
    } motion_t;

    // One input item as the block sees it
    typedef struct packed {
        cmd_t                       cmd;
        logic [TIME_W-1:0]          stamp;
        logic signed [FIELD_W-1:0]  ax;
        logic signed [FIELD_W-1:0]  ay;
        logic signed [FIELD_W-1:0]  az;
        logic signed [FIELD_W-1:0]  gx;
        logic signed [FIELD_W-1:0]  gy;
        logic signed [FIELD_W-1:0]  gz;
    } imu_item_t;

    // ------------------------------------------------------------------------
    // DUT ports, every input known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // [31:0] sample_time, [47:32] accel_x, [63:48] accel_y, [79:64] accel_z,
    // [95:80] gyro_x, [111:96] gyro_y, [127:112] gyro_z
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // [0] cmd
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [0] accepted, [1] is_static, [7:2] static_level, [39:8] newest_time
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    imu_window_static_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    imu_item_t pending_samples[$];  // items waiting for the driver
    result_t   due_results[$];      // predicted results, oldest first
    imu_item_t on_wire;             // item currently offered on s_*
    int        stall_pct = 0;       // chance of a gap per cycle, both sides
    int        src_gap   = 0;
    int        snk_gap   = 0;
    int        errors    = 0;
    int        result_cnt = 0;
    int        quiet_cycles = 0;

    // Predictor copy of the detector
    imu_item_t               window_ring [WINDOW_LEN];
    int                      ring_slot  = 0;
    int                      ring_fill  = 0;
    longint                  acc_sum [3];
    longint                  gyr_sum [3];
    longint                  acc_sq_sum = 0;
    logic [TIME_W-1:0]       newest_stamp = '0;
    bit                      have_stamp = 1'b0;
    logic [LEVEL_W-1:0]      still_count = '0;
    logic [ACC_THR_W-1:0]    acc_var_limit = 32'd400;
    logic [GYRO_THR_W-1:0]   gyro_mean_limit = 16'd10;

    // Stimulus shaping
    logic [TIME_W-1:0]       stamp_hi = '0;
    int                      acc_base [3];
    int                      spin_bias;

    initial begin
        for (int k = 0; k < 3; k++) begin
            acc_sum[k] = 0;
            gyr_sum[k] = 0;
            acc_base[k] = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Window predictor: apply one item, return the result it must produce
    // ------------------------------------------------------------------------
    function automatic result_t detector_step(input imu_item_t it);
        result_t   res;
        imu_item_t old;
        longint    a [3];
        longint    g [3];
        longint    n;
        longint    var_lhs;
        longint    var_rhs;
        longint    gyro_lhs;
        longint    gn;
        bit        pass;
        res = '0;
        a[0] = $signed(it.ax);
        a[1] = $signed(it.ay);
        a[2] = $signed(it.az);
        g[0] = $signed(it.gx);
        g[1] = $signed(it.gy);
        g[2] = $signed(it.gz);
        if (it.cmd == CMD_FEED) begin
            // Store only a strictly later sample; the first one always goes in
            if (!have_stamp || it.stamp > newest_stamp) begin
                if (ring_fill == WINDOW_LEN) begin
                    // Retire the oldest sample from the running sums
                    old = window_ring[ring_slot];
                    acc_sum[0] -= $signed(old.ax);
                    acc_sum[1] -= $signed(old.ay);
                    acc_sum[2] -= $signed(old.az);
                    gyr_sum[0] -= $signed(old.gx);
                    gyr_sum[1] -= $signed(old.gy);
                    gyr_sum[2] -= $signed(old.gz);
                    acc_sq_sum -= longint'($signed(old.ax)) * $signed(old.ax);
                    acc_sq_sum -= longint'($signed(old.ay)) * $signed(old.ay);
                    acc_sq_sum -= longint'($signed(old.az)) * $signed(old.az);
                end else begin
                    ring_fill++;
                end
                for (int k = 0; k < 3; k++) begin
                    acc_sum[k] += a[k];
                    gyr_sum[k] += g[k];
                    acc_sq_sum += a[k] * a[k];
                end
                window_ring[ring_slot] = it;
                ring_slot = (ring_slot == WINDOW_LEN - 1) ? 0 : ring_slot + 1;
                newest_stamp = it.stamp;
                have_stamp = 1'b1;
                res.accepted = 1'b1;
            end
        end else if (ring_fill == WINDOW_LEN) begin
            // Variance and mean tests, scaled by N to stay in integers
            n = WINDOW_LEN;
            var_lhs = n * acc_sq_sum - (acc_sum[0] * acc_sum[0] +
                      acc_sum[1] * acc_sum[1] + acc_sum[2] * acc_sum[2]);
            var_rhs = longint'(acc_var_limit) * n * n;
            gyro_lhs = gyr_sum[0] * gyr_sum[0] + gyr_sum[1] * gyr_sum[1] +
                       gyr_sum[2] * gyr_sum[2];
            gn = longint'(gyro_mean_limit) * n;
            pass = (var_lhs < var_rhs) && (gyro_lhs < gn * gn);
            if (pass) begin
                if (still_count < STATIC_LIMIT)
                    still_count++;
            end else if (still_count > 0) begin
                still_count--;
            end
        end
        // A query on a window that is not yet full never reports static
        res.is_static    = (still_count == STATIC_LIMIT) &&
                           !(it.cmd == CMD_QUERY && ring_fill != WINDOW_LEN);
        res.static_level = still_count;
        res.newest_time  = newest_stamp;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line each, and count it
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, result_cnt, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next pending item, predict it on the transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                due_results.insert(due_results.size(), detector_step(on_wire));
            // Hold the payload while the block stalls us
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                    // Insert a random gap before the next item
                    src_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    on_wire = pending_samples[0];
                    pending_samples.delete(0);
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_wire.gz, on_wire.gy, on_wire.gx,
                                 on_wire.az, on_wire.ay, on_wire.ax, on_wire.stamp};
                    s_tuser  <= on_wire.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer, throttle ready in bursts
    // ------------------------------------------------------------------------
    result_t got;
    result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %b want %b",
                                                  got.accepted, want.accepted));
                    if (got.is_static !== want.is_static)
                        report_mismatch($sformatf("is_static got %b want %b",
                                                  got.is_static, want.is_static));
                    if (got.static_level !== want.static_level)
                        report_mismatch($sformatf("static_level got %0d want %0d",
                                                  got.static_level, want.static_level));
                    if (got.newest_time !== want.newest_time)
                        report_mismatch($sformatf("newest_time got %h want %h",
                                                  got.newest_time, want.newest_time));
                end
                result_cnt++;
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                snk_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("imu_window_static_detector_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [FIELD_W-1:0] vary(input int center, input int spread);
        return FIELD_W'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic push_item(input cmd_t c, input logic [TIME_W-1:0] st,
                             input int ax, input int ay, input int az,
                             input int gx, input int gy, input int gz);
        imu_item_t it;
        it.cmd   = c;
        it.stamp = st;
        it.ax = FIELD_W'(ax);
        it.ay = FIELD_W'(ay);
        it.az = FIELD_W'(az);
        it.gx = FIELD_W'(gx);
        it.gy = FIELD_W'(gy);
        it.gz = FIELD_W'(gz);
        pending_samples.insert(pending_samples.size(), it);
    endtask

    // A query carries random payload that the block must ignore
    task automatic push_query();
        imu_item_t it;
        it = {CMD_QUERY, $urandom(), $urandom(), $urandom(), $urandom()};
        it.cmd = CMD_QUERY;
        pending_samples.insert(pending_samples.size(), it);
    endtask

    // Feed one sample; a stale one repeats or undercuts the newest stamp
    task automatic push_feed(input motion_t m, input bit stale);
        imu_item_t it;
        it.cmd = CMD_FEED;
        if (stale) begin
            it.stamp = stamp_hi - $urandom_range(0, (stamp_hi > 1000) ? 1000 : stamp_hi);
        end else begin
            // Mostly short steps apart, now and then a long dropout
            if ($urandom_range(0, 15) == 0)
                stamp_hi += $urandom_range(1, 1 << 20);
            else
                stamp_hi += $urandom_range(1, 5000);
            it.stamp = stamp_hi;
        end
        it.ax = vary(acc_base[0], 8);
        it.ay = vary(acc_base[1], 8);
        it.az = vary(acc_base[2], 8);
        it.gx = vary(0, 4);
        it.gy = vary(0, 4);
        it.gz = vary(0, 4);
        case (m)
            MOTION_SHAKE: begin
                it.ax = vary(acc_base[0], 3000);
                it.ay = vary(acc_base[1], 3000);
                it.az = vary(acc_base[2], 3000);
            end
            MOTION_SPIN: begin
                it.gx = vary(spin_bias, 8);
                it.gy = vary(-spin_bias / 2, 8);
                it.gz = vary(spin_bias / 3, 8);
            end
            MOTION_WILD: begin
                {it.ax, it.ay, it.az} = (3 * FIELD_W)'({$urandom(), $urandom()});
                {it.gx, it.gy, it.gz} = (3 * FIELD_W)'({$urandom(), $urandom()});
            end
            default: begin
            end
        endcase
        pending_samples.insert(pending_samples.size(), it);
    endtask

    // Wait until every item is sent and every result is back, then let the
    // pipeline drain; sample away from the active edge
    task automatic settle();
        do
            @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write while the block is idle; mirror it in the predictor
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_ACC_VAR_THR)
            acc_var_limit = val;
        else
            gyro_mean_limit = val[GYRO_THR_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int good;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty window, first sample at time zero, repeated and
        // earlier stamps, full-scale counts, queries before the window fills
        stall_pct = 0;
        push_query();
        push_item(CMD_FEED, 32'd0, -32768, 32767, 0, 32767, -32768, -1);
        push_item(CMD_FEED, 32'd0, 1, 2, 3, 4, 5, 6);
        push_item(CMD_FEED, 32'd100, 32767, -32768, -1, -32768, 32767, 0);
        push_item(CMD_FEED, 32'd50, 7, 7, 7, 7, 7, 7);
        push_item(CMD_FEED, 32'd100, 9, 9, 9, 9, 9, 9);
        push_query();
        push_item(CMD_FEED, 32'd101, 32767, 32767, 32767, 32767, 32767, 32767);
        push_item(CMD_FEED, 32'd102, -32768, -32768, -32768, -32768, -32768, -32768);
        push_query();
        stamp_hi = 32'd102;
        settle();

        // Fill the window with a resting device at a random attitude; enough
        // good samples to push the full-scale ones back out
        for (int k = 0; k < 3; k++)
            acc_base[k] = int'($urandom_range(0, 40000)) - 20000;
        stall_pct = 25;
        good = 0;
        while (good < 215) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                push_query();
            end else if (pick < 15) begin
                push_feed(MOTION_QUIET, 1'b1);
            end else begin
                push_feed(MOTION_QUIET, 1'b0);
                good++;
            end
        end
        settle();

        // Keep resting and query often: counter climbs and saturates
        stall_pct = 0;
        for (int i = 0; i < 90; i++) begin
            if ($urandom_range(0, 99) < 70)
                push_query();
            else
                push_feed(MOTION_QUIET, 1'b0);
        end
        settle();

        // Start moving: shaking breaks the variance test, spinning the gyro test
        spin_bias = int'($urandom_range(200, 2000));
        if ($urandom_range(0, 1) == 1)
            spin_bias = -spin_bias;
        stall_pct = 40;
        for (int i = 0; i < 60; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_query();
            else if (pick < 70)
                push_feed(MOTION_SHAKE, 1'b0);
            else
                push_feed(MOTION_SPIN, 1'b0);
        end
        settle();

        // Widest limits: anything passes
        write_reg(REG_ACC_VAR_THR, 32'hFFFF_FFFF);
        write_reg(REG_GYRO_MEAN_THR, 32'h0000_FFFF);
        stall_pct = 25;
        for (int i = 0; i < 60; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_query();
            else if (pick < 45)
                push_feed(MOTION_WILD, 1'b1);
            else
                push_feed(MOTION_WILD, 1'b0);
        end
        settle();

        // Zero limits: nothing passes, so the counter only walks down
        write_reg(REG_ACC_VAR_THR, 32'h0);
        write_reg(REG_GYRO_MEAN_THR, 32'h0);
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 99) < 50)
                push_query();
            else
                push_feed(MOTION_WILD, 1'b0);
        end
        settle();

        // Random limits
        write_reg(REG_ACC_VAR_THR, $urandom());
        write_reg(REG_GYRO_MEAN_THR, $urandom_range(0, 65535));
        for (int i = 0; i < 20; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_query();
            else if (pick < 70)
                push_feed(MOTION_QUIET, 1'b0);
            else
                push_feed(MOTION_SHAKE, 1'b0);
        end
        settle();

        // Back to reset limits; no idling from here to the end
        write_reg(REG_ACC_VAR_THR, 32'd400);
        write_reg(REG_GYRO_MEAN_THR, 32'd10);
        stall_pct = 0;
        for (int i = 0; i < 40; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                push_query();
            else if (pick < 70)
                push_feed(MOTION_QUIET, 1'b0);
            else if (pick < 85)
                push_feed(MOTION_SHAKE, 1'b0);
            else if (pick < 95)
                push_feed(MOTION_SPIN, 1'b0);
            else
                push_feed(MOTION_QUIET, 1'b1);
        end
        // Top of the timestamp range; nothing later can follow it
        push_item(CMD_FEED, 32'hFFFF_FFFF, 12, -12, 4000, 1, -1, 0);
        push_item(CMD_FEED, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        push_item(CMD_FEED, 32'd5, 0, 0, 0, 0, 0, 0);
        push_query();
        settle();

        if (errors == 0)
            $display("imu_window_static_detector_tb: clean");
        else
            $display("imu_window_static_detector_tb: errors");
        $finish;
    end

endmodule
